@@ rtl/pce_pkg.sv @@
// Package for the correlation engine: widths, codes and the command and status
// structs passed between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pce_pkg;

  localparam int SAMPLE_W = 16;    // port width of one sample
  localparam int COUNT_W  = 13;    // pair counter, holds up to 4096
  localparam int SUM_W    = 29;    // signed sum of samples
  localparam int SQ_W     = 43;    // unsigned sum of squares
  localparam int XY_W     = 44;    // signed sum of products
  localparam int VAR_W    = 56;    // variance terms
  localparam int NUM_W    = 56;    // numerator magnitude
  localparam int PROD_W   = 112;   // vx*vy and num^2
  localparam int LIMB_W   = 32;    // multiplier operand width
  localparam int MAG_W    = 128;   // operand magnitude, four limbs
  localparam int ACC_W    = 160;   // product accumulator
  localparam int K_W      = 16;    // search bounds, 0..32768
  localparam int K_FULL   = 32768;
  localparam int CORR_MAX = 32767;

  localparam int DEF_MAX_PAIRS   = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_ZERO_DEN = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_VX, ST_VY, ST_NUM, ST_CHK, ST_DPRD, ST_NSQ,
    ST_SQ, ST_MUL, ST_LOOP, ST_FIN
  } state_t;

  // Multiplier operand sources
  typedef enum logic [3:0] {
    OPND_N, OPND_SXX, OPND_SYY, OPND_SXY, OPND_SX, OPND_SY,
    OPND_VX, OPND_VY, OPND_NUM, OPND_D, OPND_O, OPND_O2
  } opnd_t;

  // Where the accumulator goes when a product sequence is done
  typedef enum logic [2:0] {
    DST_NONE, DST_VX, DST_VY, DST_NUM, DST_D, DST_N2, DST_O2
  } dest_t;

  typedef struct packed {
    logic       in_ready;
    logic       mul_go;
    opnd_t      a_sel;
    logic [1:0] a_limb;
    opnd_t      b_sel;
    logic [1:0] b_limb;
    logic [1:0] shift;
    logic       neg;
    dest_t      dst;
    logic       cmp;
    logic       search_init;
    logic       finish;
  } pce_cmd_t;

  typedef struct packed {
    logic pipe_valid;
    logic pipe_last;
    logic overflow;
    logic vars_pos;
    logic lo_lt_hi;
    logic out_free;
  } pce_stat_t;

  // One multiply-accumulate step: acc +/- (a.limb * b.limb) << 32*shift
  function automatic pce_cmd_t mul_cmd(opnd_t a, logic [1:0] al, opnd_t b,
                                       logic [1:0] bl, logic [1:0] sh, logic neg);
    pce_cmd_t c;
    c        = '0;
    c.mul_go = 1'b1;
    c.a_sel  = a;
    c.a_limb = al;
    c.b_sel  = b;
    c.b_limb = bl;
    c.shift  = sh;
    c.neg    = neg;
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pce_if.sv @@
// Valid/ready channel interfaces for the sample pairs and the results.
// Depends on pce_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pce_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [pce_pkg::SAMPLE_W-1:0] x_value;
  logic signed [pce_pkg::SAMPLE_W-1:0] y_value;
  logic                                last_pair;

  modport source(output valid, output x_value, output y_value, output last_pair,
                 input ready);
  modport sink(input valid, input x_value, input y_value, input last_pair,
               output ready);
endinterface

interface pce_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pce_pkg::SAMPLE_W-1:0] correlation;
  logic [1:0]                          status;
  logic [pce_pkg::COUNT_W-1:0]         pair_count;

  modport source(output valid, output correlation, output status, output pair_count,
                 input ready);
  modport sink(input valid, input correlation, input status, input pair_count,
               output ready);
endinterface

`default_nettype wire

@@ rtl/pce_ctrl.sv @@
// Controller: sequences accumulation, the variance and numerator products, the
// binary search over the result and the result hand-off. Depends on pce_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pce_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  pce_pkg::pce_stat_t stat,
  output pce_pkg::pce_cmd_t  cmd
);
  import pce_pkg::*;

  state_t     state, state_next;
  logic [2:0] step;

  // State and step registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= 3'd0;
    end else begin
      state <= state_next;
      step  <= (state_next != state) ? 3'd0 : step + 3'd1;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (stat.pipe_valid && stat.pipe_last) state_next = ST_START;
      ST_START: state_next = stat.overflow ? ST_FIN : ST_VX;
      ST_VX:    if (step == 3'd4) state_next = ST_VY;
      ST_VY:    if (step == 3'd4) state_next = ST_NUM;
      ST_NUM:   if (step == 3'd4) state_next = ST_CHK;
      ST_CHK:   state_next = stat.vars_pos ? ST_DPRD : ST_FIN;
      ST_DPRD:  if (step == 3'd5) state_next = ST_NSQ;
      ST_NSQ:   if (step == 3'd5) state_next = ST_LOOP;
      ST_SQ:    if (step == 3'd2) state_next = ST_MUL;
      ST_MUL:   if (step == 3'd5) state_next = ST_LOOP;
      ST_LOOP:  state_next = stat.lo_lt_hi ? ST_SQ : ST_FIN;
      ST_FIN:   if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Commands: issue steps, then an empty drain step, then the store or compare
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: cmd.in_ready = !(stat.pipe_valid && stat.pipe_last);
      ST_VX: begin
        case (step)
          3'd0:    cmd = mul_cmd(OPND_N, 2'd0, OPND_SXX, 2'd0, 2'd0, 1'b0);
          3'd1:    cmd = mul_cmd(OPND_N, 2'd0, OPND_SXX, 2'd1, 2'd1, 1'b0);
          3'd2:    cmd = mul_cmd(OPND_SX, 2'd0, OPND_SX, 2'd0, 2'd0, 1'b1);
          3'd4:    cmd.dst = DST_VX;
          default: cmd = '0;
        endcase
      end
      ST_VY: begin
        case (step)
          3'd0:    cmd = mul_cmd(OPND_N, 2'd0, OPND_SYY, 2'd0, 2'd0, 1'b0);
          3'd1:    cmd = mul_cmd(OPND_N, 2'd0, OPND_SYY, 2'd1, 2'd1, 1'b0);
          3'd2:    cmd = mul_cmd(OPND_SY, 2'd0, OPND_SY, 2'd0, 2'd0, 1'b1);
          3'd4:    cmd.dst = DST_VY;
          default: cmd = '0;
        endcase
      end
      ST_NUM: begin
        case (step)
          3'd0:    cmd = mul_cmd(OPND_N, 2'd0, OPND_SXY, 2'd0, 2'd0, 1'b0);
          3'd1:    cmd = mul_cmd(OPND_N, 2'd0, OPND_SXY, 2'd1, 2'd1, 1'b0);
          3'd2:    cmd = mul_cmd(OPND_SX, 2'd0, OPND_SY, 2'd0, 2'd0, 1'b1);
          3'd4:    cmd.dst = DST_NUM;
          default: cmd = '0;
        endcase
      end
      ST_CHK: cmd.search_init = 1'b1;
      ST_DPRD: begin
        case (step)
          3'd0:    cmd = mul_cmd(OPND_VX, 2'd0, OPND_VY, 2'd0, 2'd0, 1'b0);
          3'd1:    cmd = mul_cmd(OPND_VX, 2'd0, OPND_VY, 2'd1, 2'd1, 1'b0);
          3'd2:    cmd = mul_cmd(OPND_VX, 2'd1, OPND_VY, 2'd0, 2'd1, 1'b0);
          3'd3:    cmd = mul_cmd(OPND_VX, 2'd1, OPND_VY, 2'd1, 2'd2, 1'b0);
          3'd5:    cmd.dst = DST_D;
          default: cmd = '0;
        endcase
      end
      ST_NSQ: begin
        case (step)
          3'd0:    cmd = mul_cmd(OPND_NUM, 2'd0, OPND_NUM, 2'd0, 2'd0, 1'b0);
          3'd1:    cmd = mul_cmd(OPND_NUM, 2'd0, OPND_NUM, 2'd1, 2'd1, 1'b0);
          3'd2:    cmd = mul_cmd(OPND_NUM, 2'd1, OPND_NUM, 2'd0, 2'd1, 1'b0);
          3'd3:    cmd = mul_cmd(OPND_NUM, 2'd1, OPND_NUM, 2'd1, 2'd2, 1'b0);
          3'd5:    cmd.dst = DST_N2;
          default: cmd = '0;
        endcase
      end
      ST_SQ: begin
        case (step)
          3'd0:    cmd = mul_cmd(OPND_O, 2'd0, OPND_O, 2'd0, 2'd0, 1'b0);
          3'd2:    cmd.dst = DST_O2;
          default: cmd = '0;
        endcase
      end
      ST_MUL: begin
        case (step)
          3'd0, 3'd1, 3'd2, 3'd3:
                   cmd = mul_cmd(OPND_O2, 2'd0, OPND_D, step[1:0], step[1:0], 1'b0);
          3'd5:    cmd.cmp = 1'b1;
          default: cmd = '0;
        endcase
      end
      ST_FIN:  cmd.finish = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/pce_datapath.sv @@
// Datapath: input stage, running sums, one shared 32x32 multiplier with a wide
// accumulator, search bounds and the result register. Depends on pce_pkg, pce_if.
`timescale 1ns / 1ps
`default_nettype none

module pce_datapath #(
  parameter int MAX_PAIRS   = pce_pkg::DEF_MAX_PAIRS,
  parameter int SAMPLE_BITS = pce_pkg::DEF_SAMPLE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  pce_pkg::pce_cmd_t  cmd,
  output pce_pkg::pce_stat_t stat,
  pce_in_if.sink             in_pair,
  pce_out_if.source          result
);
  import pce_pkg::*;

  localparam int EXT = SAMPLE_W - SAMPLE_BITS;

  logic                       accept;
  logic signed [SAMPLE_W-1:0] xs_sh, ys_sh, xs, ys;

  // input stage: samples and their products
  logic                         pipe_valid, pipe_last;
  logic signed [SAMPLE_W-1:0]   pipe_x, pipe_y;
  logic signed [2*SAMPLE_W-1:0] pipe_xx, pipe_yy, pipe_xy;

  // running sums
  logic [COUNT_W-1:0]      count;
  logic                    overflow;
  logic signed [SUM_W-1:0] sum_x, sum_y;
  logic [SQ_W-1:0]         sum_xx, sum_yy;
  logic signed [XY_W-1:0]  sum_xy;
  logic [SUM_W-1:0]        sx_abs, sy_abs;
  logic [XY_W-1:0]         sxy_abs;

  // product stage and accumulator
  logic [2*LIMB_W-1:0] prod;
  logic                prod_valid, prod_neg;
  logic [1:0]          prod_shift;
  logic [ACC_W-1:0]    acc, acc_abs, term;

  // stored intermediate values
  logic [VAR_W-1:0]  vx, vy;
  logic              vx_pos, vy_pos;
  logic [NUM_W-1:0]  num_abs;
  logic              num_neg;
  logic [PROD_W-1:0] dprod, n2;
  logic [LIMB_W-1:0] o2;

  // search bounds
  logic [K_W-1:0] lo, hi, mid;
  logic [K_W:0]   mid_sum, o_full;

  logic [MAG_W-1:0]  a_mag, b_mag;
  logic              a_sgn, b_sgn;
  logic [LIMB_W-1:0] a_limb, b_limb;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_corr;
  logic [1:0]                 out_status;
  logic [COUNT_W-1:0]         out_count;

  assign in_pair.ready = cmd.in_ready;
  assign accept        = in_pair.valid && in_pair.ready;

  // Sign extension from SAMPLE_BITS
  assign xs_sh = in_pair.x_value << EXT;
  assign ys_sh = in_pair.y_value << EXT;
  assign xs    = xs_sh >>> EXT;
  assign ys    = ys_sh >>> EXT;

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid <= 1'b0;
    end else begin
      pipe_valid <= accept;
    end
    if (accept) begin
      pipe_x    <= xs;
      pipe_y    <= ys;
      pipe_xx   <= xs * xs;
      pipe_yy   <= ys * ys;
      pipe_xy   <= xs * ys;
      pipe_last <= in_pair.last_pair;
    end
  end

  // Accumulate one pair; pairs past the limit only mark overflow
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      count    <= '0;
      overflow <= 1'b0;
      sum_x    <= '0;
      sum_y    <= '0;
      sum_xx   <= '0;
      sum_yy   <= '0;
      sum_xy   <= '0;
    end else if (pipe_valid) begin
      if (count >= COUNT_W'(MAX_PAIRS)) begin
        overflow <= 1'b1;
      end else begin
        count  <= count + COUNT_W'(1);
        sum_x  <= sum_x + SUM_W'(pipe_x);
        sum_y  <= sum_y + SUM_W'(pipe_y);
        sum_xx <= sum_xx + SQ_W'(unsigned'(pipe_xx));
        sum_yy <= sum_yy + SQ_W'(unsigned'(pipe_yy));
        sum_xy <= sum_xy + XY_W'(pipe_xy);
      end
    end
  end

  assign sx_abs  = sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
  assign sy_abs  = sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);
  assign sxy_abs = sum_xy[XY_W-1] ? XY_W'(-sum_xy) : XY_W'(sum_xy);

  assign mid_sum = {1'b0, lo} + {1'b0, hi} + (K_W + 1)'(1);
  assign mid     = mid_sum[K_W:1];
  assign o_full  = {mid, 1'b0} - (K_W + 1)'(1);

  // Operand A select
  always_comb begin
    a_sgn = 1'b0;
    case (cmd.a_sel)
      OPND_N:   a_mag = MAG_W'(count);
      OPND_SXX: a_mag = MAG_W'(sum_xx);
      OPND_SYY: a_mag = MAG_W'(sum_yy);
      OPND_SXY: begin a_mag = MAG_W'(sxy_abs); a_sgn = sum_xy[XY_W-1]; end
      OPND_SX:  begin a_mag = MAG_W'(sx_abs);  a_sgn = sum_x[SUM_W-1]; end
      OPND_SY:  begin a_mag = MAG_W'(sy_abs);  a_sgn = sum_y[SUM_W-1]; end
      OPND_VX:  a_mag = MAG_W'(vx);
      OPND_VY:  a_mag = MAG_W'(vy);
      OPND_NUM: a_mag = MAG_W'(num_abs);
      OPND_D:   a_mag = MAG_W'(dprod);
      OPND_O:   a_mag = MAG_W'(o_full);
      OPND_O2:  a_mag = MAG_W'(o2);
      default:  a_mag = '0;
    endcase
  end

  // Operand B select
  always_comb begin
    b_sgn = 1'b0;
    case (cmd.b_sel)
      OPND_N:   b_mag = MAG_W'(count);
      OPND_SXX: b_mag = MAG_W'(sum_xx);
      OPND_SYY: b_mag = MAG_W'(sum_yy);
      OPND_SXY: begin b_mag = MAG_W'(sxy_abs); b_sgn = sum_xy[XY_W-1]; end
      OPND_SX:  begin b_mag = MAG_W'(sx_abs);  b_sgn = sum_x[SUM_W-1]; end
      OPND_SY:  begin b_mag = MAG_W'(sy_abs);  b_sgn = sum_y[SUM_W-1]; end
      OPND_VX:  b_mag = MAG_W'(vx);
      OPND_VY:  b_mag = MAG_W'(vy);
      OPND_NUM: b_mag = MAG_W'(num_abs);
      OPND_D:   b_mag = MAG_W'(dprod);
      OPND_O:   b_mag = MAG_W'(o_full);
      OPND_O2:  b_mag = MAG_W'(o2);
      default:  b_mag = '0;
    endcase
  end

  assign a_limb = a_mag[LIMB_W*cmd.a_limb +: LIMB_W];
  assign b_limb = b_mag[LIMB_W*cmd.b_limb +: LIMB_W];

  // Shared multiplier, registered product
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= cmd.mul_go;
    end
    prod       <= a_limb * b_limb;
    prod_neg   <= cmd.neg ^ a_sgn ^ b_sgn;
    prod_shift <= cmd.shift;
  end

  assign term    = ACC_W'(prod) << (LIMB_W * prod_shift);
  assign acc_abs = acc[ACC_W-1] ? -acc : acc;

  // Accumulator; cleared when its value is stored or compared
  always_ff @(posedge clk) begin
    if (rst || cmd.dst != DST_NONE || cmd.cmp) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= prod_neg ? acc - term : acc + term;
    end
  end

  // Stores and the search step
  always_ff @(posedge clk) begin
    if (rst) begin
      vx_pos <= 1'b0;
      vy_pos <= 1'b0;
    end else begin
      case (cmd.dst)
        DST_VX: vx_pos <= !acc[ACC_W-1] && (acc != '0);
        DST_VY: vy_pos <= !acc[ACC_W-1] && (acc != '0);
        default: ;
      endcase
    end
    case (cmd.dst)
      DST_VX:  vx <= acc[VAR_W-1:0];
      DST_VY:  vy <= acc[VAR_W-1:0];
      DST_NUM: begin
        num_neg <= acc[ACC_W-1];
        num_abs <= acc_abs[NUM_W-1:0];
      end
      DST_D:   dprod <= acc[PROD_W-1:0];
      DST_N2:  n2 <= acc[PROD_W-1:0];
      DST_O2:  o2 <= acc[LIMB_W-1:0];
      default: ;
    endcase
    if (cmd.search_init) begin
      lo <= '0;
      hi <= K_W'(K_FULL);
    end else if (cmd.cmp) begin
      // keep mid when (2*mid-1)^2 * vx*vy <= (num << 16)^2
      if (acc <= ACC_W'({n2, LIMB_W'(0)})) begin
        lo <= mid;
      end else begin
        hi <= mid - K_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.finish) begin
      out_count <= count;
      if (overflow) begin
        out_corr   <= '0;
        out_status <= STATUS_OVERFLOW;
      end else if (!(vx_pos && vy_pos)) begin
        out_corr   <= '0;
        out_status <= STATUS_ZERO_DEN;
      end else begin
        out_status <= STATUS_OK;
        if (num_neg) begin
          out_corr <= SAMPLE_W'(-lo);
        end else if (lo > K_W'(CORR_MAX)) begin
          out_corr <= SAMPLE_W'(CORR_MAX);
        end else begin
          out_corr <= SAMPLE_W'(lo);
        end
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.correlation = out_corr;
  assign result.status      = out_status;
  assign result.pair_count  = out_count;

  assign stat.pipe_valid = pipe_valid;
  assign stat.pipe_last  = pipe_last;
  assign stat.overflow   = overflow;
  assign stat.vars_pos   = vx_pos && vy_pos;
  assign stat.lo_lt_hi   = lo < hi;
  assign stat.out_free   = !out_valid || result.ready;

endmodule

`default_nettype wire

@@ rtl/pearson_correlation_engine.sv @@
// Top level of the correlation engine: controller plus datapath.
// Depends on pce_pkg, pce_if, pce_ctrl, pce_datapath.
//
// Channel   Dir  Payload                                  Transaction
// in_pair   in   x_value[15:0] y_value[15:0] last_pair    valid && ready
// result    out  correlation[15:0] status[1:0]            valid && ready
//                pair_count[12:0]
//
// Pairs are taken one per cycle while a set accumulates.
// After the last pair, the single 32x32 multiplier computes the variances and the
// numerator, then runs the 15 or 16 step binary search for the rounded coefficient;
// a zero denominator skips the search, an overflowed set skips all products.
// in_pair.ready is low while a result is computed and while the result register
// is still full at the end. Synchronous reset clears control state and sums.
`timescale 1ns / 1ps
`default_nettype none

module pearson_correlation_engine #(
  parameter int MAX_PAIRS   = pce_pkg::DEF_MAX_PAIRS,
  parameter int SAMPLE_BITS = pce_pkg::DEF_SAMPLE_BITS
) (
  input  logic      clk,
  input  logic      rst,
  pce_in_if.sink    in_pair,
  pce_out_if.source result
);
  import pce_pkg::*;

  pce_cmd_t  cmd;
  pce_stat_t stat;

  pce_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  pce_datapath #(
    .MAX_PAIRS   (MAX_PAIRS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .in_pair (in_pair),
    .result  (result)
  );

  // A new result appears only from a finish command
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.finish))
    else $error("result valid without finish");

  // Finish never overwrites a result that is still waiting
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!result.valid || result.ready))
    else $error("finish while result register busy");

  // Multiplier issue never coincides with an accumulator store or compare
  a_issue_alone: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_go |-> (cmd.dst == DST_NONE && !cmd.cmp))
    else $error("multiply issued with store");

  // No pair is taken behind a pending last pair
  a_no_accept_after_last: assert property (@(posedge clk) disable iff (rst)
    (in_pair.valid && in_pair.ready) |-> !(stat.pipe_valid && stat.pipe_last))
    else $error("pair accepted behind last pair");

endmodule

`default_nettype wire
